### sv/sbm_pkg.sv
// Shared types and constants for the selection box merger.
package sbm_pkg;

  localparam int IDX_W  = 16;
  localparam int CRD_W  = 16;
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [1:0] REQ_START = 2'd0;
  localparam logic [1:0] REQ_ELEM  = 2'd1;
  localparam logic [1:0] REQ_END   = 2'd2;

  typedef logic signed [CRD_W-1:0] coord_t;

  typedef enum logic [1:0] {
    CMD_START,
    CMD_GLYPH,
    CMD_END
  } sbm_cmd_e;

  typedef struct packed {
    sbm_cmd_e cmd;
    coord_t   left;
    coord_t   top;
    coord_t   right;
    coord_t   bottom;
  } sbm_cmd_t;

endpackage

### sv/sbm_req_if.sv
// Request channel: start, page element and end-of-list beats.
interface sbm_req_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  req_type;
  logic [sbm_pkg::IDX_W-1:0]   sel_first;
  logic [sbm_pkg::IDX_W-1:0]   sel_second;
  logic                        is_char;
  logic [sbm_pkg::IDX_W-1:0]   char_index;
  logic signed [sbm_pkg::CRD_W-1:0] left;
  logic signed [sbm_pkg::CRD_W-1:0] top;
  logic signed [sbm_pkg::CRD_W-1:0] right;
  logic signed [sbm_pkg::CRD_W-1:0] bottom;

  modport source (
    output valid, req_type, sel_first, sel_second, is_char, char_index,
           left, top, right, bottom,
    input  ready
  );
  modport sink (
    input  valid, req_type, sel_first, sel_second, is_char, char_index,
           left, top, right, bottom,
    output ready
  );
endinterface

### sv/sbm_res_if.sv
// Result channel: merged highlight rectangles.
interface sbm_res_if;
  logic                             valid;
  logic                             ready;
  logic signed [sbm_pkg::CRD_W-1:0] out_left;
  logic signed [sbm_pkg::CRD_W-1:0] out_top;
  logic signed [sbm_pkg::CRD_W-1:0] out_right;
  logic signed [sbm_pkg::CRD_W-1:0] out_bottom;
  logic                             is_empty;
  logic                             last_run;

  modport source (
    output valid, out_left, out_top, out_right, out_bottom, is_empty, last_run,
    input  ready
  );
  modport sink (
    input  valid, out_left, out_top, out_right, out_bottom, is_empty, last_run,
    output ready
  );
endinterface

### sv/sbm_front.sv
// Front end: tracks selection range and list position, forwards selected glyphs.
module sbm_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  sbm_req_if.sink           req,
  output logic              push_valid_o,
  output sbm_pkg::sbm_cmd_t push_data_o,
  input  logic              push_ready_i
);
  import sbm_pkg::*;

  logic [IDX_W-1:0] pos_q, pos_d;
  logic [IDX_W:0]   exp_q, exp_d;
  logic [IDX_W-1:0] low_q, low_d;
  logic [IDX_W-1:0] high_q, high_d;
  logic             accept;
  logic             selected;
  logic             swap;

  assign req.ready = push_ready_i;
  assign accept    = req.valid && req.ready;
  assign swap      = req.sel_first > req.sel_second;

  assign selected = (pos_q >= low_q) && (exp_q <= {1'b0, high_q}) && req.is_char &&
                    ({1'b0, req.char_index} == exp_q);

  always_comb begin
    pos_d              = pos_q;
    exp_d              = exp_q;
    low_d              = low_q;
    high_d             = high_q;
    push_valid_o       = 1'b0;
    push_data_o.cmd    = CMD_GLYPH;
    push_data_o.left   = req.left;
    push_data_o.top    = req.top;
    push_data_o.right  = req.right;
    push_data_o.bottom = req.bottom;
    case (req.req_type)
      REQ_START: begin
        push_valid_o    = req.valid;
        push_data_o.cmd = CMD_START;
        if (accept) begin
          low_d  = swap ? req.sel_second : req.sel_first;
          high_d = swap ? req.sel_first : req.sel_second;
          pos_d  = '0;
          exp_d  = {1'b0, low_d};
        end
      end
      REQ_ELEM: begin
        push_valid_o    = req.valid && selected;
        push_data_o.cmd = CMD_GLYPH;
        if (accept) begin
          // saturate the list position
          if (pos_q != '1) pos_d = pos_q + 1'b1;
          if (selected) exp_d = exp_q + 1'b1;
        end
      end
      REQ_END: begin
        push_valid_o    = req.valid;
        push_data_o.cmd = CMD_END;
        if (accept) exp_d = {1'b0, high_q} + 1'b1;
      end
      default: begin
        push_valid_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      exp_q  <= '0;
      low_q  <= '0;
      high_q <= '0;
    end else begin
      pos_q  <= pos_d;
      exp_q  <= exp_d;
      low_q  <= low_d;
      high_q <= high_d;
    end
  end

endmodule

### sv/sbm_queue.sv
// Small command queue between front and back.
module sbm_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_valid_i,
  input  sbm_pkg::sbm_cmd_t push_data_i,
  output logic              push_ready_o,
  output logic              pop_valid_o,
  output sbm_pkg::sbm_cmd_t pop_data_o,
  input  logic              pop_ready_i
);
  import sbm_pkg::*;

  sbm_cmd_t          mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] count_q;
  logic              push_fire, pop_fire;

  assign push_ready_o = count_q != QCNT_W'(QDEPTH);
  assign pop_valid_o  = count_q != '0;
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push_fire    = push_valid_i && push_ready_o;
  assign pop_fire     = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i) begin
    if (push_fire) mem_q[wr_ptr_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_fire) wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      if (pop_fire)  rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      if (push_fire && !pop_fire)      count_q <= count_q + 1'b1;
      else if (pop_fire && !push_fire) count_q <= count_q - 1'b1;
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= QCNT_W'(QDEPTH))
    else $error("queue count exceeds depth");
  a_count_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_fire && !pop_fire) |=> count_q == $past(count_q) + 1'b1)
    else $error("queue count did not advance on push");
  a_count_down: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_fire && !push_fire) |=> count_q == $past(count_q) - 1'b1)
    else $error("queue count did not drop on pop");
`endif

endmodule

### sv/sbm_back.sv
// Back end: merges selected glyph boxes and drives the result register.
module sbm_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              pop_valid_i,
  input  sbm_pkg::sbm_cmd_t pop_data_i,
  output logic              pop_ready_o,
  sbm_res_if.source         res
);
  import sbm_pkg::*;

  localparam int WIDE = CRD_W + 3;

  coord_t ol_q, ot_q, or_q, ob_q;
  coord_t ol_d, ot_d, or_d, ob_d;
  logic   open_q, open_d;

  logic   valid_q, valid_d;
  coord_t rl_q, rt_q, rr_q, rb_q;
  coord_t rl_d, rt_d, rr_d, rb_d;
  logic   empty_q, empty_d, last_q, last_d;

  logic signed [WIDE-1:0] w_ol, w_ot, w_or, w_ob, w_gl, w_gt, w_gb;
  logic signed [WIDE-1:0] diff, total;
  logic                   overlap, join_box, fire, emit;

  assign pop_ready_o = !valid_q || res.ready;
  assign fire        = pop_valid_i && pop_ready_o;

  assign w_ol = WIDE'(ol_q);
  assign w_ot = WIDE'(ot_q);
  assign w_or = WIDE'(or_q);
  assign w_ob = WIDE'(ob_q);
  assign w_gl = WIDE'(pop_data_i.left);
  assign w_gt = WIDE'(pop_data_i.top);
  assign w_gb = WIDE'(pop_data_i.bottom);

  // |diff| <= total, written as a two-sided range check
  assign diff     = (w_ot + w_ob) - (w_gt + w_gb);
  assign total    = (w_ob - w_ot) + (w_gb - w_gt);
  assign overlap  = (diff <= total) && (-total <= diff);
  assign join_box = open_q && overlap && ((w_gl - w_or) < (w_or - w_ol));

  always_comb begin
    ol_d    = ol_q;
    ot_d    = ot_q;
    or_d    = or_q;
    ob_d    = ob_q;
    open_d  = open_q;
    emit    = 1'b0;
    rl_d    = rl_q;
    rt_d    = rt_q;
    rr_d    = rr_q;
    rb_d    = rb_q;
    empty_d = empty_q;
    last_d  = last_q;
    if (fire) begin
      case (pop_data_i.cmd)
        CMD_START: begin
          open_d = 1'b0;
        end
        CMD_GLYPH: begin
          if (join_box) begin
            or_d = pop_data_i.right;
            if (pop_data_i.top < ot_q)    ot_d = pop_data_i.top;
            if (pop_data_i.bottom > ob_q) ob_d = pop_data_i.bottom;
          end else begin
            if (open_q) begin
              emit    = 1'b1;
              rl_d    = ol_q;
              rt_d    = ot_q;
              rr_d    = or_q;
              rb_d    = ob_q;
              empty_d = 1'b0;
              last_d  = 1'b0;
            end
            ol_d   = pop_data_i.left;
            ot_d   = pop_data_i.top;
            or_d   = pop_data_i.right;
            ob_d   = pop_data_i.bottom;
            open_d = 1'b1;
          end
        end
        CMD_END: begin
          emit    = 1'b1;
          rl_d    = open_q ? ol_q : '0;
          rt_d    = open_q ? ot_q : '0;
          rr_d    = open_q ? or_q : '0;
          rb_d    = open_q ? ob_q : '0;
          empty_d = !open_q;
          last_d  = 1'b1;
          open_d  = 1'b0;
        end
        default: begin
          open_d = open_q;
        end
      endcase
    end
    valid_d = emit || (valid_q && !res.ready);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q  <= 1'b0;
      valid_q <= 1'b0;
      ol_q    <= '0;
      ot_q    <= '0;
      or_q    <= '0;
      ob_q    <= '0;
    end else begin
      open_q  <= open_d;
      valid_q <= valid_d;
      ol_q    <= ol_d;
      ot_q    <= ot_d;
      or_q    <= or_d;
      ob_q    <= ob_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rl_q    <= rl_d;
    rt_q    <= rt_d;
    rr_q    <= rr_d;
    rb_q    <= rb_d;
    empty_q <= empty_d;
    last_q  <= last_d;
  end

  assign res.valid      = valid_q;
  assign res.out_left   = rl_q;
  assign res.out_top    = rt_q;
  assign res.out_right  = rr_q;
  assign res.out_bottom = rb_q;
  assign res.is_empty   = empty_q;
  assign res.last_run   = last_q;

`ifndef NO_ASSERTIONS
  a_end_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && pop_data_i.cmd == CMD_END) |=> (!open_q && valid_q && last_q))
    else $error("end of list did not flush the open box");
  a_start_drops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && pop_data_i.cmd == CMD_START) |=> !open_q)
    else $error("start did not drop the open box");
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && !res.ready) |-> !emit)
    else $error("result overwritten while stalled");
`endif

endmodule

### sv/selection_box_merger.sv
// Top level of the selection box merger.
//
// Usage: send a start beat (req_type 0) with the two selection endpoints,
// then page element beats (req_type 1) in list order, then an end beat
// (req_type 2). Selected glyph boxes are merged into highlight rectangles,
// returned on the result channel. The end beat always yields one result
// flagged last_run; is_empty marks a selection that produced no rectangle.
// Throughput: one request beat per cycle, sustained, while results drain.
// Path: an accepted beat is written into the command queue; the merge unit
// then pops it and writes any result it causes into the result register.
// The front stage decides selection from the list position and expected
// index; a two-entry queue decouples it from the merge unit.
// Stall: when the receiver holds ready low the result register holds its
// beat, the merge unit stops, and req ready drops once the queue is full.
// Reset clears range, position, open box and all valid flags; no beat is
// pending afterwards.
module selection_box_merger (
  input  logic      clk_i,
  input  logic      rst_ni,
  sbm_req_if.sink   req_i,
  sbm_res_if.source res_o
);
  import sbm_pkg::*;

  logic     push_valid, push_ready, pop_valid, pop_ready;
  sbm_cmd_t push_data, pop_data;

  sbm_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req          (req_i),
    .push_valid_o (push_valid),
    .push_data_o  (push_data),
    .push_ready_i (push_ready)
  );

  sbm_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_data_i  (push_data),
    .push_ready_o (push_ready),
    .pop_valid_o  (pop_valid),
    .pop_data_o   (pop_data),
    .pop_ready_i  (pop_ready)
  );

  sbm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_data_i  (pop_data),
    .pop_ready_o (pop_ready),
    .res         (res_o)
  );

endmodule

### verif/selection_box_merger_test.sv
// Self-checking testbench for the selection box merger: directed table, then random runs.
module selection_box_merger_test;
  timeunit 1ns;
  timeprecision 1ps;

  import sbm_pkg::*;

  localparam logic [1:0] REQ_UNUSED = 2'd3;

  localparam int RANDOM_BEATS = 800;
  localparam int CYCLE_LIMIT  = 500_000;
  localparam int DRAIN_TAIL   = 8;
  localparam int SEND_IDLE_PCT [4] = '{0, 52, 0, 31};
  localparam int STALL_PCT     [4] = '{0, 0, 52, 31};

  typedef logic [IDX_W-1:0] idx_t;

  typedef struct packed {
    logic [1:0] kind;
    idx_t       first;
    idx_t       second;
    logic       is_char;
    idx_t       cidx;
    coord_t     left;
    coord_t     top;
    coord_t     right;
    coord_t     bottom;
  } beat_t;

  typedef struct packed {
    coord_t left;
    coord_t top;
    coord_t right;
    coord_t bottom;
    logic   empty;
    logic   last;
  } rect_t;

  typedef struct packed {
    beat_t beat;
    logic  typed;
    rect_t want;
  } row_t;

  localparam rect_t NO_RECT   = '0;
  localparam rect_t EMPTY_RUN = '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b1, 1'b1};

  localparam row_t DIRECTED [23] = '{
    // glyph before any start: reset range is 0..0
    '{'{REQ_ELEM, 16'd0, 16'd0, 1'b1, 16'd0, 16'sd16, 16'sd0, 16'sd32, 16'sd16}, 1'b0, NO_RECT},
    '{'{REQ_END, 16'd0, 16'd0, 1'b0, 16'd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b1,
      '{16'sd16, 16'sd0, 16'sd32, 16'sd16, 1'b0, 1'b1}},
    '{'{REQ_END, 16'd0, 16'd0, 1'b0, 16'd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b1, EMPTY_RUN},
    // past the high endpoint after the end beat
    '{'{REQ_ELEM, 16'd0, 16'd0, 1'b1, 16'd1, 16'sd48, 16'sd0, 16'sd64, 16'sd16}, 1'b0, NO_RECT},
    '{'{REQ_UNUSED, 16'hFFFF, 16'hFFFF, 1'b1, 16'hFFFF, 16'sh7FFF, 16'sh8000, 16'sh7FFF,
        16'sh8000}, 1'b0, NO_RECT},
    // endpoints out of order, full range
    '{'{REQ_START, 16'hFFFF, 16'd0, 1'b0, 16'd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b0, NO_RECT},
    '{'{REQ_ELEM, 16'd0, 16'd0, 1'b1, 16'd0, 16'sh8000, 16'sh8000, -16'sd32752, -16'sd32752},
      1'b0, NO_RECT},
    '{'{REQ_ELEM, 16'd0, 16'd0, 1'b1, 16'd1, -16'sd32750, -16'sd32760, -16'sd32736,
        -16'sd32740}, 1'b0, NO_RECT},
    '{'{REQ_ELEM, 16'd0, 16'd0, 1'b0, 16'd2, 16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh8000},
      1'b0, NO_RECT},
    // wide horizontal gap, then a vertical break
    '{'{REQ_ELEM, 16'd0, 16'd0, 1'b1, 16'd2, 16'sd0, -16'sd32760, 16'sd16, -16'sd32744},
      1'b0, NO_RECT},
    '{'{REQ_ELEM, 16'd0, 16'd0, 1'b1, 16'd3, 16'sd20, -16'sd32000, 16'sd36, -16'sd31984},
      1'b0, NO_RECT},
    '{'{REQ_ELEM, 16'd0, 16'd0, 1'b1, 16'd5, 16'sd40, -16'sd32000, 16'sd56, -16'sd31984},
      1'b0, NO_RECT},
    '{'{REQ_ELEM, 16'd0, 16'd0, 1'b1, 16'd4, 16'sd38, -16'sd31998, 16'sd50, -16'sd31986},
      1'b0, NO_RECT},
    '{'{REQ_END, 16'd0, 16'd0, 1'b0, 16'd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b0, NO_RECT},
    // one-character range reached at list position 3
    '{'{REQ_START, 16'd3, 16'd3, 1'b0, 16'd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b0, NO_RECT},
    '{'{REQ_ELEM, 16'd0, 16'd0, 1'b1, 16'd3, 16'sd0, 16'sd0, 16'sd16, 16'sd16}, 1'b0, NO_RECT},
    '{'{REQ_ELEM, 16'd0, 16'd0, 1'b0, 16'd3, 16'sd0, 16'sd0, 16'sd16, 16'sd16}, 1'b0, NO_RECT},
    '{'{REQ_ELEM, 16'd0, 16'd0, 1'b0, 16'd3, 16'sd0, 16'sd0, 16'sd16, 16'sd16}, 1'b0, NO_RECT},
    '{'{REQ_ELEM, 16'd0, 16'd0, 1'b1, 16'd3, 16'sd32000, 16'sd32000, 16'sh7FFF, 16'sh7FFF},
      1'b0, NO_RECT},
    '{'{REQ_ELEM, 16'd0, 16'd0, 1'b1, 16'd4, 16'sd0, 16'sd0, 16'sd16, 16'sd16}, 1'b0, NO_RECT},
    '{'{REQ_END, 16'd0, 16'd0, 1'b0, 16'd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b1,
      '{16'sd32000, 16'sd32000, 16'sh7FFF, 16'sh7FFF, 1'b0, 1'b1}},
    '{'{REQ_START, 16'd0, 16'd0, 1'b0, 16'd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b0, NO_RECT},
    '{'{REQ_END, 16'd0, 16'd0, 1'b0, 16'd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b1, EMPTY_RUN}
  };

  logic clk_i;
  logic rst_ni;

  sbm_req_if req_if ();
  sbm_res_if res_if ();

  selection_box_merger u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .res_o  (res_if)
  );

  rect_t pending_rects [$];
  int    mismatches    = 0;
  int    sent_beats    = 0;
  int    send_idle_pct = 0;
  int    stall_pct     = 0;
  int    cycle_count   = 0;

  // merger state as the block should hold it
  idx_t           pos_q     = '0;
  logic [IDX_W:0] next_idx  = '0;
  idx_t           lo_idx    = '0;
  idx_t           hi_idx    = '0;
  coord_t         run_left  = '0;
  coord_t         run_top   = '0;
  coord_t         run_right = '0;
  coord_t         run_bot   = '0;
  logic           run_open  = 1'b0;

  // text layout cursor for well-formed glyph streams
  int pen_x, pen_y, line_h, margin_x;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string msg);
    $display("ERROR at %0t: %s", $time, msg);
    mismatches++;
  endtask

  task automatic compare_field(input string name, input int got, input int want);
    if (got != want) begin
      report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
    end
  endtask

  function automatic logic merge_step(input beat_t b, output rect_t r);
    int   vdist, vspan;
    logic merges;
    logic emit;
    idx_t pos;
    emit   = 1'b0;
    merges = 1'b0;
    r      = '0;
    case (b.kind)
      REQ_START: begin
        lo_idx   = (b.first <= b.second) ? b.first : b.second;
        hi_idx   = (b.first <= b.second) ? b.second : b.first;
        pos_q    = '0;
        next_idx = {1'b0, lo_idx};
        run_open = 1'b0;
      end
      REQ_ELEM: begin
        pos = pos_q;
        if (pos_q != '1) pos_q = pos_q + 1'b1;
        if (pos >= lo_idx && next_idx <= {1'b0, hi_idx} && b.is_char &&
            {1'b0, b.cidx} == next_idx) begin
          if (run_open) begin
            // compare doubled centers against the summed heights
            vdist = (int'(run_top) + int'(run_bot)) - (int'(b.top) + int'(b.bottom));
            if (vdist < 0) vdist = -vdist;
            vspan = (int'(run_bot) - int'(run_top)) + (int'(b.bottom) - int'(b.top));
            if (vdist <= vspan) begin
              merges = (int'(b.left) - int'(run_right)) < (int'(run_right) - int'(run_left));
            end
          end
          if (merges) begin
            run_right = b.right;
            if (b.top < run_top) run_top = b.top;
            if (b.bottom > run_bot) run_bot = b.bottom;
          end else begin
            if (run_open) begin
              r    = '{run_left, run_top, run_right, run_bot, 1'b0, 1'b0};
              emit = 1'b1;
            end
            run_left  = b.left;
            run_top   = b.top;
            run_right = b.right;
            run_bot   = b.bottom;
            run_open  = 1'b1;
          end
          next_idx = next_idx + 1'b1;
        end
      end
      REQ_END: begin
        if (run_open) r = '{run_left, run_top, run_right, run_bot, 1'b0, 1'b1};
        else r = EMPTY_RUN;
        run_open = 1'b0;
        next_idx = {1'b0, hi_idx} + 1'b1;
        emit     = 1'b1;
      end
      default: ;
    endcase
    return emit;
  endfunction

  function automatic beat_t random_beat();
    logic [127:0] bits;
    bits = {$urandom(), $urandom(), $urandom(), $urandom()};
    return bits[$bits(beat_t)-1:0];
  endfunction

  function automatic void place_glyph(inout beat_t b);
    int roll, l, r, t;
    roll = $urandom_range(0, 99);
    if (roll < 4) pen_x += int'($urandom_range(200, 2000));
    if (roll >= 95 || pen_x > 31000) begin
      pen_x = margin_x;
      pen_y += line_h + int'($urandom_range(0, 64));
    end
    if (pen_y > 32000 - line_h) pen_y = int'($urandom_range(0, 1000)) - 32000;
    l = pen_x + int'($urandom_range(0, 48));
    r = l + int'($urandom_range(16, 200));
    if (r > 32767) r = 32767;
    t = pen_y + int'($urandom_range(0, 16)) - 8;
    b.left   = coord_t'(l);
    b.right  = coord_t'(r);
    b.top    = coord_t'(t);
    b.bottom = coord_t'(t + line_h);
    pen_x = r;
  endfunction

  // enter and leave at a falling edge; valid is only lowered by an idle gap or a drain
  task automatic send_beat(input beat_t b, input logic typed, input rect_t want);
    rect_t made;
    logic  emit;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
      @(negedge clk_i);
    end
    req_if.valid      <= 1'b1;
    req_if.req_type   <= b.kind;
    req_if.sel_first  <= b.first;
    req_if.sel_second <= b.second;
    req_if.is_char    <= b.is_char;
    req_if.char_index <= b.cidx;
    req_if.left       <= b.left;
    req_if.top        <= b.top;
    req_if.right      <= b.right;
    req_if.bottom     <= b.bottom;
    do @(posedge clk_i); while (req_if.ready !== 1'b1);
    emit = merge_step(b, made);
    if (typed) pending_rects = {pending_rects, want};
    else if (emit) pending_rects = {pending_rects, made};
    sent_beats++;
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    req_if.valid <= 1'b0;
    do @(negedge clk_i); while (pending_rects.size() != 0);
  endtask

  task automatic check_result();
    rect_t got, want;
    got = '{res_if.out_left, res_if.out_top, res_if.out_right, res_if.out_bottom,
            res_if.is_empty, res_if.last_run};
    if (pending_rects.size() == 0) begin
      report_mismatch($sformatf("unexpected rect l=%0d t=%0d r=%0d b=%0d empty=%0b last=%0b",
                                got.left, got.top, got.right, got.bottom, got.empty, got.last));
    end else begin
      want = pending_rects.pop_front();
      compare_field("out_left", got.left, want.left);
      compare_field("out_top", got.top, want.top);
      compare_field("out_right", got.right, want.right);
      compare_field("out_bottom", got.bottom, want.bottom);
      compare_field("is_empty", got.empty, want.empty);
      compare_field("last_run", got.last, want.last);
    end
  endtask

  always @(negedge clk_i) begin
    res_if.ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (rst_ni && res_if.valid && res_if.ready) check_result();
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    beat_t b;
    int    lo, hi, n, chars, roll, phase;
    rst_ni            = 1'b0;
    req_if.valid      = 1'b0;
    req_if.req_type   = REQ_START;
    req_if.sel_first  = '0;
    req_if.sel_second = '0;
    req_if.is_char    = 1'b0;
    req_if.char_index = '0;
    req_if.left       = '0;
    req_if.top        = '0;
    req_if.right      = '0;
    req_if.bottom     = '0;
    res_if.ready      = 1'b0;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (int i = 0; i < $size(DIRECTED); i++) begin
      send_beat(DIRECTED[i].beat, DIRECTED[i].typed, DIRECTED[i].want);
    end
    wait_drained();

    sent_beats = 0;
    phase      = 0;
    while (sent_beats < RANDOM_BEATS) begin
      if (sent_beats * 4 / RANDOM_BEATS != phase) begin
        wait_drained();
        phase = sent_beats * 4 / RANDOM_BEATS;
      end
      send_idle_pct = SEND_IDLE_PCT[phase];
      stall_pct     = STALL_PCT[phase];

      roll = $urandom_range(0, 9);
      if (roll == 0) begin
        lo = $urandom_range(0, 65535);
        hi = $urandom_range(0, 65535);
        n  = $urandom_range(1, 12);
      end else begin
        lo = $urandom_range(0, 4);
        hi = lo + int'($urandom_range(0, 40));
        n  = hi + int'($urandom_range(0, 6));
      end
      b = random_beat();
      b.kind = REQ_START;
      if ($urandom_range(0, 1) == 1) begin
        b.first  = idx_t'(lo);
        b.second = idx_t'(hi);
      end else begin
        b.first  = idx_t'(hi);
        b.second = idx_t'(lo);
      end
      send_beat(b, 1'b0, NO_RECT);

      pen_x    = int'($urandom_range(0, 50000)) - 32000;
      margin_x = pen_x;
      pen_y    = int'($urandom_range(0, 60000)) - 32000;
      line_h   = $urandom_range(64, 256);
      chars    = 0;
      for (int k = 0; k < n; k++) begin
        roll = $urandom_range(0, 99);
        b = random_beat();
        if (roll < 85) begin
          b.kind    = REQ_ELEM;
          b.is_char = 1'b1;
          b.cidx    = idx_t'(chars);
          chars++;
          place_glyph(b);
        end else if (roll < 93) begin
          b.kind    = REQ_ELEM;
          b.is_char = 1'b0;
        end else if (roll < 97) begin
          // stray index and arbitrary box
          b.kind    = REQ_ELEM;
          b.is_char = 1'b1;
        end
        send_beat(b, 1'b0, NO_RECT);
      end

      // occasionally drop the end beat so the next start discards the open run
      roll = $urandom_range(0, 99);
      if (roll >= 5) begin
        b = random_beat();
        b.kind = REQ_END;
        send_beat(b, 1'b0, NO_RECT);
        if (roll < 12) begin
          b = random_beat();
          b.kind    = REQ_ELEM;
          b.is_char = 1'b1;
          b.cidx    = idx_t'(chars);
          place_glyph(b);
          send_beat(b, 1'b0, NO_RECT);
          b = random_beat();
          b.kind = REQ_END;
          send_beat(b, 1'b0, NO_RECT);
        end
      end
    end

    wait_drained();
    repeat (DRAIN_TAIL) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

### sim.f
sv/sbm_pkg.sv
sv/sbm_req_if.sv
sv/sbm_res_if.sv
sv/sbm_front.sv
sv/sbm_queue.sv
sv/sbm_back.sv
sv/selection_box_merger.sv
verif/selection_box_merger_test.sv
